// ----- rtl/core/nsp_pkg.sv -----
// Shared types, constants and helpers of the NMEA sentence parser.
// Depends on nothing; every other file of the block but nsp_in_if imports it.
`default_nettype none

package nsp_pkg;

	localparam int unsigned FIELD_INDEX_BITS_DEF = 6;
	localparam int unsigned QUEUE_DEPTH_DEF      = 2;

	localparam logic [7:0] CHAR_DOLLAR = 8'h24;
	localparam logic [7:0] CHAR_BANG   = 8'h21;
	localparam logic [7:0] CHAR_STAR   = 8'h2A;
	localparam logic [7:0] CHAR_COMMA  = 8'h2C;

	localparam logic [23:0] TYPE_VDM = 24'h56444D;
	localparam logic [23:0] TYPE_VDO = 24'h56444F;

	localparam int unsigned MIN_LENGTH        = 6;
	localparam int unsigned MIN_AIS_FIELDS    = 7;
	localparam int unsigned AIS_PAYLOAD_FIELD = 5;

	localparam logic [1:0] REC_CHAR      = 2'd0;
	localparam logic [1:0] REC_FIELD_END = 2'd1;
	localparam logic [1:0] REC_VERDICT   = 2'd2;

	localparam logic [2:0] ST_VALID     = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_START = 3'd2;
	localparam logic [2:0] ST_NO_STAR   = 3'd3;
	localparam logic [2:0] ST_NOT_HEX   = 3'd4;
	localparam logic [2:0] ST_MISMATCH  = 3'd5;

	localparam logic [1:0] CLS_STANDARD = 2'd0;
	localparam logic [1:0] CLS_AIS      = 2'd1;
	localparam logic [1:0] CLS_OTHER    = 2'd2;

	// one classified byte as it travels from the front end to the back end
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       is_star;
		logic       is_comma;
		logic       is_bang;
		logic       start_ok;
		logic       hex_ok;
		logic [3:0] hex_val;
	} beat_t;

	function automatic beat_t classify(input logic [7:0] b, input logic fin);
		beat_t r;
		r.data_byte = b;
		r.last      = fin;
		r.is_star   = (b == CHAR_STAR);
		r.is_comma  = (b == CHAR_COMMA);
		r.is_bang   = (b == CHAR_BANG);
		r.start_ok  = (b == CHAR_DOLLAR) || (b == CHAR_BANG);
		r.hex_ok    = 1'b1;
		r.hex_val   = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.hex_val = 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.hex_val = 4'(b - 8'h37);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.hex_val = 4'(b - 8'h57);
		end else begin
			r.hex_ok = 1'b0;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/nsp_in_if.sv -----
// Byte channel into the parser: valid/ready handshake with one sentence byte.
// Depends on nothing.
`default_nettype none

interface nsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/nsp_out_if.sv -----
// Record channel out of the parser: valid/ready handshake with one record.
// Depends on nsp_pkg for the default field index width.
`default_nettype none

interface nsp_out_if
	import nsp_pkg::*;
#(
	parameter int unsigned FIELD_INDEX_BITS = FIELD_INDEX_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [1:0]                  record_kind;
	logic [FIELD_INDEX_BITS-1:0] field_index;
	logic [7:0]                  char_byte;
	logic                        in_ais_payload;
	logic [2:0]                  status;
	logic [1:0]                  sentence_class;
	logic [15:0]                 talker_word;
	logic [23:0]                 type_word;
	logic [FIELD_INDEX_BITS-1:0] field_count;
	logic [7:0]                  checksum_computed;

	modport source (
		output valid, output record_kind, output field_index, output char_byte,
		output in_ais_payload, output status, output sentence_class, output talker_word,
		output type_word, output field_count, output checksum_computed,
		input ready
	);
	modport sink (
		input valid, input record_kind, input field_index, input char_byte,
		input in_ais_payload, input status, input sentence_class, input talker_word,
		input type_word, input field_count, input checksum_computed,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/core/nsp_front.sv -----
// Front end: takes sentence bytes, classifies them and registers one beat.
// Depends on nsp_pkg and nsp_in_if.
`default_nettype none

module nsp_front
	import nsp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	nsp_in_if.sink    sentence,
	output beat_t     beat,
	output logic      beat_valid,
	input  wire logic beat_ready
);

	logic  v_s1;
	beat_t beat_s1;
	logic  advance;

	assign advance        = !v_s1 || beat_ready;
	assign sentence.ready = advance;
	assign beat_valid     = v_s1;
	assign beat           = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= sentence.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && sentence.valid) begin
			beat_s1 <= classify(sentence.data_byte, sentence.last);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/nsp_queue.sv -----
// Short queue of classified beats between front end and back end.
// Depends on nsp_pkg for the beat type.
`default_nettype none

module nsp_queue
	import nsp_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF  // 2 or more
)(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire beat_t wr_beat,
	input  wire logic  wr_valid,
	output logic       wr_ready,
	output beat_t      rd_beat,
	output logic       rd_valid,
	input  wire logic  rd_ready
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	beat_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_beat  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_beat;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/nsp_back.sv -----
// Back end: sentence state, record generation and the output register.
// Depends on nsp_pkg and nsp_out_if.
`default_nettype none

module nsp_back
	import nsp_pkg::*;
#(
	parameter int unsigned FIELD_INDEX_BITS = FIELD_INDEX_BITS_DEF
)(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire beat_t beat,
	input  wire logic  beat_valid,
	output logic       beat_ready,
	nsp_out_if.source  records
);

	localparam int unsigned W = FIELD_INDEX_BITS;
	localparam logic [W-1:0] FIELD_MAX = {W{1'b1}};

	typedef enum logic [1:0] {
		DIGIT_NONE,
		DIGIT_ONE,
		DIGIT_TWO,
		DIGIT_BAD
	} digit_t;

	// sentence state
	logic [2:0]   pos_q;
	logic         encap_q;
	logic         start_bad_q;
	logic [7:0]   xor_q;
	logic         star_q;
	logic [1:0]   bas_q;
	logic [7:0]   rc_q;
	digit_t       digit_q;
	logic [15:0]  talker_q;
	logic [23:0]  type_q;
	logic [W-1:0] fc_q;

	// output register
	logic         out_v_q;
	logic [1:0]   kind_q;
	logic [W-1:0] idx_q;
	logic [7:0]   char_q;
	logic         ais_q;
	logic [2:0]   status_q;
	logic [1:0]   class_q;
	logic [15:0]  talker_out_q;
	logic [23:0]  type_out_q;
	logic [W-1:0] count_out_q;
	logic [7:0]   xor_out_q;

	// next state
	logic [2:0]   pos_n;
	logic         encap_n;
	logic         start_bad_n;
	logic [7:0]   xor_n;
	logic         star_n;
	logic [1:0]   bas_n;
	logic [7:0]   rc_n;
	digit_t       digit_n;
	logic [15:0]  talker_n;
	logic [23:0]  type_n;
	logic [W-1:0] fc_n;

	logic         have_rec;
	logic [1:0]   rec_kind;
	logic         rec_ais;
	logic         vd_type;
	logic [W-1:0] count;
	logic [2:0]   verdict;
	logic [1:0]   cls;
	logic         pop;
	logic         emit;

	assign beat_ready = !out_v_q || records.ready;
	assign pop        = beat_valid && beat_ready;

	always_comb begin
		pos_n       = (pos_q == 3'd7) ? pos_q : pos_q + 3'd1;
		encap_n     = encap_q;
		start_bad_n = start_bad_q;
		xor_n       = xor_q;
		star_n      = star_q;
		bas_n       = bas_q;
		rc_n        = rc_q;
		digit_n     = digit_q;
		talker_n    = talker_q;
		type_n      = type_q;
		fc_n        = fc_q;
		have_rec    = 1'b0;
		rec_kind    = REC_CHAR;
		rec_ais     = 1'b0;

		// capture the header by position
		case (pos_q)
			3'd0: begin
				encap_n     = beat.is_bang;
				start_bad_n = !beat.start_ok;
			end
			3'd1: talker_n[15:8] = beat.data_byte;
			3'd2: talker_n[7:0]  = beat.data_byte;
			3'd3: type_n[23:16]  = beat.data_byte;
			3'd4: type_n[15:8]   = beat.data_byte;
			3'd5: type_n[7:0]    = beat.data_byte;
			default: ;
		endcase

		vd_type = (type_n == TYPE_VDM) || (type_n == TYPE_VDO);

		if (!star_q) begin
			if (beat.is_star) begin
				star_n = 1'b1;
			end else begin
				have_rec = 1'b1;
				if (beat.is_comma) begin
					rec_kind = REC_FIELD_END;
					if (fc_q != FIELD_MAX) begin
						fc_n = fc_q + 1'b1;
					end
				end else begin
					rec_ais = encap_n && (fc_q == W'(AIS_PAYLOAD_FIELD)) && vd_type;
				end
				if (pos_q != 3'd0) begin
					xor_n = xor_q ^ beat.data_byte;
				end
			end
		end else begin
			// checksum digits: first one sets the value, a second hex one extends it
			if (bas_q == 2'd0) begin
				if (beat.hex_ok) begin
					digit_n = DIGIT_ONE;
					rc_n    = {4'd0, beat.hex_val};
				end else begin
					digit_n = DIGIT_BAD;
				end
			end else if (bas_q == 2'd1 && digit_q == DIGIT_ONE && beat.hex_ok) begin
				rc_n    = {rc_q[3:0], beat.hex_val};
				digit_n = DIGIT_TWO;
			end
			if (bas_q != 2'd3) begin
				bas_n = bas_q + 2'd1;
			end
		end

		count = (fc_n == FIELD_MAX) ? FIELD_MAX : fc_n + 1'b1;

		if ({1'b0, pos_q} + 4'd1 < 4'(MIN_LENGTH)) begin
			verdict = ST_SHORT;
		end else if (start_bad_n) begin
			verdict = ST_BAD_START;
		end else if (!star_n || bas_n < 2'd2) begin
			verdict = ST_NO_STAR;
		end else if (digit_n == DIGIT_NONE || digit_n == DIGIT_BAD) begin
			verdict = ST_NOT_HEX;
		end else if (rc_n != xor_n) begin
			verdict = ST_MISMATCH;
		end else begin
			verdict = ST_VALID;
		end

		if (!encap_n) begin
			cls = CLS_STANDARD;
		end else if (vd_type && count >= W'(MIN_AIS_FIELDS)) begin
			cls = CLS_AIS;
		end else begin
			cls = CLS_OTHER;
		end

		emit = pop && (beat.last || have_rec);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			encap_q     <= 1'b0;
			start_bad_q <= 1'b0;
			xor_q       <= '0;
			star_q      <= 1'b0;
			bas_q       <= '0;
			rc_q        <= '0;
			digit_q     <= DIGIT_NONE;
			talker_q    <= '0;
			type_q      <= '0;
			fc_q        <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (pop) begin
				if (beat.last) begin
					// sentence done: back to the idle state for the next one
					pos_q       <= '0;
					encap_q     <= 1'b0;
					start_bad_q <= 1'b0;
					xor_q       <= '0;
					star_q      <= 1'b0;
					bas_q       <= '0;
					rc_q        <= '0;
					digit_q     <= DIGIT_NONE;
					talker_q    <= '0;
					type_q      <= '0;
					fc_q        <= '0;
				end else begin
					pos_q       <= pos_n;
					encap_q     <= encap_n;
					start_bad_q <= start_bad_n;
					xor_q       <= xor_n;
					star_q      <= star_n;
					bas_q       <= bas_n;
					rc_q        <= rc_n;
					digit_q     <= digit_n;
					talker_q    <= talker_n;
					type_q      <= type_n;
					fc_q        <= fc_n;
				end
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (records.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (beat.last) begin
				kind_q       <= REC_VERDICT;
				idx_q        <= '0;
				char_q       <= '0;
				ais_q        <= 1'b0;
				status_q     <= verdict;
				class_q      <= cls;
				talker_out_q <= talker_n;
				type_out_q   <= type_n;
				count_out_q  <= count;
				xor_out_q    <= xor_n;
			end else begin
				kind_q       <= rec_kind;
				idx_q        <= fc_q;
				char_q       <= beat.data_byte;
				ais_q        <= rec_ais;
				status_q     <= ST_VALID;
				class_q      <= CLS_STANDARD;
				talker_out_q <= '0;
				type_out_q   <= '0;
				count_out_q  <= '0;
				xor_out_q    <= '0;
			end
		end
	end

	assign records.valid             = out_v_q;
	assign records.record_kind       = kind_q;
	assign records.field_index       = idx_q;
	assign records.char_byte         = char_q;
	assign records.in_ais_payload    = ais_q;
	assign records.status            = status_q;
	assign records.sentence_class    = class_q;
	assign records.talker_word       = talker_out_q;
	assign records.type_word         = type_out_q;
	assign records.field_count       = count_out_q;
	assign records.checksum_computed = xor_out_q;

endmodule

`default_nettype wire

// ----- rtl/core/nmea_sentence_parser_unit.sv -----
// NMEA 0183 sentence parser: one byte per beat in, one record per beat out.
// Throughput: one byte per cycle while records.ready stays high; back-pressure from the sink stalls the input.
// The byte of a record passes the front register, a queue entry, then the back-end output
// register before the record is presented, and is held there while the output is stalled.
// Reset: arst_n clears all sentence state and empties the queue; no clearing pass.
// Depends on nsp_pkg, nsp_in_if, nsp_out_if, nsp_front, nsp_queue and nsp_back.
`default_nettype none

module nmea_sentence_parser_unit
	import nsp_pkg::*;
#(
	parameter int unsigned FIELD_INDEX_BITS = FIELD_INDEX_BITS_DEF,  // 4 to 8
	parameter int unsigned QUEUE_DEPTH      = QUEUE_DEPTH_DEF         // 2 or more
)(
	input  wire logic clk,
	input  wire logic arst_n,
	nsp_in_if.sink    sentence,
	nsp_out_if.source records
);

	beat_t front_beat;
	logic  front_valid;
	logic  front_ready;
	beat_t queue_beat;
	logic  queue_valid;
	logic  queue_ready;

	nsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sentence   (sentence),
		.beat       (front_beat),
		.beat_valid (front_valid),
		.beat_ready (front_ready)
	);

	nsp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_beat  (front_beat),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_beat  (queue_beat),
		.rd_valid (queue_valid),
		.rd_ready (queue_ready)
	);

	nsp_back #(
		.FIELD_INDEX_BITS (FIELD_INDEX_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat       (queue_beat),
		.beat_valid (queue_valid),
		.beat_ready (queue_ready),
		.records    (records)
	);

	// a full queue always has a beat to hand on
	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!front_ready |-> queue_valid)
		else $error("queue full but reports empty");

	a_ais_in_payload_field: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.in_ais_payload |->
			records.record_kind == REC_CHAR &&
			records.field_index == FIELD_INDEX_BITS'(AIS_PAYLOAD_FIELD))
		else $error("AIS payload flag outside field five");

	a_ais_class_fields: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.record_kind == REC_VERDICT &&
			records.sentence_class == CLS_AIS |->
			records.field_count >= FIELD_INDEX_BITS'(MIN_AIS_FIELDS))
		else $error("AIS class with too few fields");

	a_verdict_clean: assert property (@(posedge clk) disable iff (!arst_n)
		records.valid && records.record_kind == REC_VERDICT |->
			records.field_index == '0 && records.char_byte == '0)
		else $error("verdict carries character fields");

endmodule

`default_nettype wire

// ----- dv/nmea_sentence_parser_unit_test.sv -----
`timescale 1ns / 1ps
// Testbench for nmea_sentence_parser_unit: directed sentences, then random sentences under
// varying idle and stall, checked record by record against an in-bench sentence predictor.
// Depends on nsp_pkg, nsp_in_if, nsp_out_if and the parser top level.

module nmea_sentence_parser_unit_test;
	import nsp_pkg::*;

	localparam int FIB         = FIELD_INDEX_BITS_DEF;
	localparam int FIELD_MAX   = (1 << FIB) - 1;
	localparam int STALL_LIMIT = 4000;
	localparam int TOTAL_BYTES = 1250;

	typedef struct packed {
		logic [1:0]     record_kind;
		logic [FIB-1:0] field_index;
		logic [7:0]     char_byte;
		logic           in_ais_payload;
		logic [2:0]     status;
		logic [1:0]     sentence_class;
		logic [15:0]    talker_word;
		logic [23:0]    type_word;
		logic [FIB-1:0] field_count;
		logic [7:0]     checksum_computed;
	} record_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       pinned;
		record_t    want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	nsp_in_if sentence_ch ();
	nsp_out_if #(.FIELD_INDEX_BITS(FIB)) record_ch ();

	nmea_sentence_parser_unit #(.FIELD_INDEX_BITS(FIB)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sentence(sentence_ch),
		.records(record_ch)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	record_t     pending_records[$];
	int          mismatch_count = 0;
	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	int          bytes_sent = 0;
	int          idle_cycles = 0;
	logic        pin_on = 1'b0;
	record_t     pin_rec = '0;

	// predictor copy of the sentence state
	logic [2:0]     m_pos;
	logic           m_bang;
	logic           m_bad_start;
	logic [7:0]     m_xor;
	logic           m_star;
	logic [1:0]     m_after;
	logic [7:0]     m_sum;
	logic [1:0]     m_digits;
	logic [15:0]    m_talker;
	logic [23:0]    m_type;
	logic [FIB-1:0] m_commas;

	// short sentence after reset, an AIS sentence with a payload character,
	// extreme bytes in the header and a checksum that is not hex
	stim_row_t directed_rows [25] = '{
		'{CHAR_DOLLAR, 1'b1, 1'b1, '{REC_VERDICT, FIB'(0), 8'h00, 1'b0, ST_SHORT,
			CLS_STANDARD, 16'h0000, 24'h000000, FIB'(1), 8'h00}},
		'{CHAR_BANG, 1'b0, 1'b0, '0},
		'{"A", 1'b0, 1'b0, '0},
		'{"I", 1'b0, 1'b0, '0},
		'{"V", 1'b0, 1'b0, '0},
		'{"D", 1'b0, 1'b0, '0},
		'{"M", 1'b0, 1'b0, '0},
		'{CHAR_COMMA, 1'b0, 1'b0, '0},
		'{CHAR_COMMA, 1'b0, 1'b0, '0},
		'{CHAR_COMMA, 1'b0, 1'b0, '0},
		'{CHAR_COMMA, 1'b0, 1'b0, '0},
		'{CHAR_COMMA, 1'b0, 1'b0, '0},
		'{"P", 1'b0, 1'b1, '{REC_CHAR, FIB'(5), 8'h50, 1'b1, ST_VALID,
			CLS_STANDARD, 16'h0000, 24'h000000, FIB'(0), 8'h00}},
		'{CHAR_COMMA, 1'b0, 1'b0, '0},
		'{CHAR_STAR, 1'b0, 1'b0, '0},
		'{"0", 1'b0, 1'b0, '0},
		'{"7", 1'b1, 1'b1, '{REC_VERDICT, FIB'(0), 8'h00, 1'b0, ST_VALID,
			CLS_AIS, 16'h4149, 24'h56444D, FIB'(7), 8'h07}},
		'{CHAR_DOLLAR, 1'b0, 1'b0, '0},
		'{8'hFF, 1'b0, 1'b1, '{REC_CHAR, FIB'(0), 8'hFF, 1'b0, ST_VALID,
			CLS_STANDARD, 16'h0000, 24'h000000, FIB'(0), 8'h00}},
		'{8'h00, 1'b0, 1'b1, '{REC_CHAR, FIB'(0), 8'h00, 1'b0, ST_VALID,
			CLS_STANDARD, 16'h0000, 24'h000000, FIB'(0), 8'h00}},
		'{"a", 1'b0, 1'b0, '0},
		'{"b", 1'b0, 1'b0, '0},
		'{CHAR_STAR, 1'b0, 1'b0, '0},
		'{"Z", 1'b0, 1'b0, '0},
		'{"0", 1'b1, 1'b1, '{REC_VERDICT, FIB'(0), 8'h00, 1'b0, ST_NOT_HEX,
			CLS_STANDARD, 16'hFF00, 24'h61622A, FIB'(1), 8'hFC}}
	};

	function automatic void clear_model();
		m_pos       = '0;
		m_bang      = 1'b0;
		m_bad_start = 1'b0;
		m_xor       = '0;
		m_star      = 1'b0;
		m_after     = '0;
		m_sum       = '0;
		m_digits    = '0;
		m_talker    = '0;
		m_type      = '0;
		m_commas    = '0;
	endfunction

	// advance the sentence state by one byte; return 1 when the byte yields a record
	function automatic logic predict_record(input logic [7:0] b, input logic fin,
			output record_t r);
		record_t     v;
		logic [2:0]  p;
		logic        emit;
		logic        hex_ok;
		logic [3:0]  hex_val;
		logic        vd_type;
		int unsigned count;
		r = '0;
		v = '0;
		p = m_pos;
		emit = 1'b0;
		hex_ok = 1'b1;
		hex_val = '0;
		if (b >= "0" && b <= "9") begin
			hex_val = 4'(b - "0");
		end else if (b >= "A" && b <= "F") begin
			hex_val = 4'(b - "A" + 8'd10);
		end else if (b >= "a" && b <= "f") begin
			hex_val = 4'(b - "a" + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end

		case (p)
			3'd0: begin
				m_bang = (b == CHAR_BANG);
				m_bad_start = !(b == CHAR_DOLLAR || b == CHAR_BANG);
			end
			3'd1: m_talker[15:8] = b;
			3'd2: m_talker[7:0] = b;
			3'd3: m_type[23:16] = b;
			3'd4: m_type[15:8] = b;
			3'd5: m_type[7:0] = b;
			default: ;
		endcase
		vd_type = (m_type == TYPE_VDM) || (m_type == TYPE_VDO);

		if (!m_star) begin
			if (b == CHAR_STAR) begin
				m_star = 1'b1;
			end else begin
				emit = 1'b1;
				r.field_index = m_commas;
				r.char_byte = b;
				if (b == CHAR_COMMA) begin
					r.record_kind = REC_FIELD_END;
					if (m_commas != FIELD_MAX) m_commas++;
				end else begin
					r.record_kind = REC_CHAR;
					r.in_ais_payload = m_bang && (m_commas == AIS_PAYLOAD_FIELD) && vd_type;
				end
				if (p != 3'd0) m_xor ^= b;
			end
		end else begin
			// only the first two bytes after the star can form the checksum
			if (m_after == 2'd0) begin
				m_digits = hex_ok ? 2'd1 : 2'd3;
				if (hex_ok) m_sum = {4'd0, hex_val};
			end else if (m_after == 2'd1 && m_digits == 2'd1 && hex_ok) begin
				m_sum = {m_sum[3:0], hex_val};
				m_digits = 2'd2;
			end
			if (m_after != 2'd3) m_after++;
		end
		if (p != 3'd7) m_pos++;

		if (fin) begin
			count = m_commas + 1;
			if (count > FIELD_MAX) count = FIELD_MAX;
			v.record_kind = REC_VERDICT;
			if (int'(p) + 1 < MIN_LENGTH) v.status = ST_SHORT;
			else if (m_bad_start) v.status = ST_BAD_START;
			else if (!m_star || m_after < 2'd2) v.status = ST_NO_STAR;
			else if (m_digits != 2'd1 && m_digits != 2'd2) v.status = ST_NOT_HEX;
			else if (m_sum != m_xor) v.status = ST_MISMATCH;
			else v.status = ST_VALID;
			if (!m_bang) v.sentence_class = CLS_STANDARD;
			else if (vd_type && count >= MIN_AIS_FIELDS) v.sentence_class = CLS_AIS;
			else v.sentence_class = CLS_OTHER;
			v.talker_word = m_talker;
			v.type_word = m_type;
			v.field_count = FIB'(count);
			v.checksum_computed = m_xor;
			clear_model();
			r = v;
			return 1'b1;
		end
		return emit;
	endfunction

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		if (mismatch_count < 40)
			$display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_record(input record_t got, input record_t want);
		if (got.record_kind !== want.record_kind)
			report_mismatch("record_kind", 24'(got.record_kind), 24'(want.record_kind));
		if (got.field_index !== want.field_index)
			report_mismatch("field_index", 24'(got.field_index), 24'(want.field_index));
		if (got.char_byte !== want.char_byte)
			report_mismatch("char_byte", 24'(got.char_byte), 24'(want.char_byte));
		if (got.in_ais_payload !== want.in_ais_payload)
			report_mismatch("in_ais_payload", 24'(got.in_ais_payload),
				24'(want.in_ais_payload));
		if (got.status !== want.status)
			report_mismatch("status", 24'(got.status), 24'(want.status));
		if (got.sentence_class !== want.sentence_class)
			report_mismatch("sentence_class", 24'(got.sentence_class),
				24'(want.sentence_class));
		if (got.talker_word !== want.talker_word)
			report_mismatch("talker_word", 24'(got.talker_word), 24'(want.talker_word));
		if (got.type_word !== want.type_word)
			report_mismatch("type_word", got.type_word, want.type_word);
		if (got.field_count !== want.field_count)
			report_mismatch("field_count", 24'(got.field_count), 24'(want.field_count));
		if (got.checksum_computed !== want.checksum_computed)
			report_mismatch("checksum_computed", 24'(got.checksum_computed),
				24'(want.checksum_computed));
	endtask

	// both handshakes are looked at in one place, inputs first
	always @(posedge clk) begin : beat_monitor
		record_t predicted;
		record_t got;
		logic    hit;
		logic    moved;
		if (arst_n) begin
			moved = 1'b0;
			if (sentence_ch.valid && sentence_ch.ready) begin
				moved = 1'b1;
				hit = predict_record(sentence_ch.data_byte, sentence_ch.last, predicted);
				if (pin_on) pending_records.insert(pending_records.size(), pin_rec);
				else if (hit) pending_records.insert(pending_records.size(), predicted);
			end
			if (record_ch.valid && record_ch.ready) begin
				moved = 1'b1;
				got = '{record_ch.record_kind, record_ch.field_index, record_ch.char_byte,
					record_ch.in_ais_payload, record_ch.status, record_ch.sentence_class,
					record_ch.talker_word, record_ch.type_word, record_ch.field_count,
					record_ch.checksum_computed};
				if (pending_records.size() == 0)
					report_mismatch("record with none expected", 24'(got.record_kind), '0);
				else
					check_record(got, pending_records.pop_front());
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	always @(negedge clk) record_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

	// called at a falling edge, returns at the falling edge after the beat
	task automatic push_byte(input logic [7:0] b, input logic fin, input logic pin,
			input record_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			sentence_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pin_on = pin;
		pin_rec = want;
		sentence_ch.valid <= 1'b1;
		sentence_ch.data_byte <= b;
		sentence_ch.last <= fin;
		do @(posedge clk); while (!sentence_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
		if (n < 4'd10) return "0" + 8'(n);
		return (lower ? "a" : "A") + 8'(n) - 8'd10;
	endfunction

	task automatic send_sentence();
		logic [7:0] q[$];
		logic [7:0] acc;
		logic [7:0] b;
		logic       lower;
		int         kind;
		int         n_fields;
		int         len;
		int         cut;
		int         i;
		kind = $urandom_range(99);
		if (kind >= 85) begin
			// noise: any bytes, from 1 to 12 of them
			len = $urandom_range(1, 12);
			repeat (len) q.insert(q.size(), 8'($urandom_range(255)));
		end else begin
			q.insert(q.size(), $urandom_range(1) ? CHAR_BANG : CHAR_DOLLAR);
			if ($urandom_range(1)) begin
				q.insert(q.size(), "A");
				q.insert(q.size(), "I");
			end else begin
				repeat (2) q.insert(q.size(), 8'($urandom_range(65, 90)));
			end
			case ($urandom_range(3))
				0: begin
					q.insert(q.size(), "V"); q.insert(q.size(), "D"); q.insert(q.size(), "M");
				end
				1: begin
					q.insert(q.size(), "V"); q.insert(q.size(), "D"); q.insert(q.size(), "O");
				end
				default: repeat (3) q.insert(q.size(), 8'($urandom_range(65, 90)));
			endcase
			// now and then 60 to 70 fields, enough to reach or saturate the count
			n_fields = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 10);
			for (i = 0; i < n_fields; i++) begin
				q.insert(q.size(), CHAR_COMMA);
				len = (n_fields > 20) ? $urandom_range(0, 1) : $urandom_range(0, 5);
				repeat (len) begin
					do begin
						if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
						else b = 8'($urandom_range(32, 126));
					end while (b == CHAR_STAR || (b == CHAR_COMMA && n_fields > 20));
					q.insert(q.size(), b);
				end
			end
			acc = '0;
			for (i = 1; i < q.size(); i++) acc ^= q[i];
			if ($urandom_range(4) == 0) acc = 8'($urandom_range(255));
			lower = 1'($urandom_range(1));
			q.insert(q.size(), CHAR_STAR);
			q.insert(q.size(), hex_char(acc[7:4], lower));
			if ($urandom_range(9) != 0) q.insert(q.size(), hex_char(acc[3:0], lower));
			case ($urandom_range(9))
				0: begin q.insert(q.size(), 8'h0D); q.insert(q.size(), 8'h0A); end
				1: q.insert(q.size(), CHAR_STAR);
				2: q.insert(q.size(), 8'($urandom_range(255)));
				default: ;
			endcase
			if (kind >= 70) begin
				// break the sentence: cut it short, drop the checksum, or spoil a byte
				case ($urandom_range(2))
					0: begin
						cut = $urandom_range(1, q.size());
						while (q.size() > cut) void'(q.pop_back());
					end
					1: begin
						for (i = 1; i < q.size(); i++) if (q[i] == CHAR_STAR) break;
						while (q.size() > i) void'(q.pop_back());
					end
					default: q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
				endcase
			end
		end
		foreach (q[k]) push_byte(q[k], k == q.size() - 1, 1'b0, '0);
	endtask

	initial begin : stimulus
		int row;
		int phase;
		clear_model();
		arst_n = 1'b0;
		sentence_ch.valid = 1'b0;
		sentence_ch.data_byte = '0;
		sentence_ch.last = 1'b0;
		record_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (row = 0; row < $size(directed_rows); row++)
			push_byte(directed_rows[row].data_byte, directed_rows[row].last,
				directed_rows[row].pinned, directed_rows[row].want);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
				default: begin src_idle_pct = 14; sink_stall_pct = 14; end
			endcase
			while (bytes_sent < (phase + 1) * TOTAL_BYTES / 4) send_sentence();
			// hold off the sender until every record of the phase is out
			sentence_ch.valid <= 1'b0;
			do @(negedge clk); while (pending_records.size() != 0);
		end

		repeat (10) @(negedge clk);
		if (pending_records.size() != 0)
			report_mismatch("records never received", 24'(pending_records.size()), '0);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
